@@ hdl/md4_pkg.sv @@
// Constants shared by the MD4 digest unit and its testbench, and the step functions of the unit.
`timescale 1ns / 1ps

package md4_pkg;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K2 = 32'h5a827999;
  localparam logic [31:0] K3 = 32'h6ed9eba1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] POS_LEN = 6'd56;
  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] STEP_LAST = 6'd48;

  localparam logic [1:0] ROUND_F = 2'd0;
  localparam logic [1:0] ROUND_G = 2'd1;

  typedef logic [31:0] word_t;

  function automatic logic [3:0] md4_word_sel(input logic [5:0] j);
    logic [3:0] k;
    k = j[3:0];
    case (j[5:4])
      ROUND_F: md4_word_sel = k;
      ROUND_G: md4_word_sel = {k[1:0], k[3:2]};
      default: md4_word_sel = {k[0], k[1], k[2], k[3]};
    endcase
  endfunction

  function automatic logic [4:0] md4_rot(input logic [5:0] j);
    case ({j[5:4], j[1:0]})
      4'b0000: md4_rot = 5'd3;
      4'b0001: md4_rot = 5'd7;
      4'b0010: md4_rot = 5'd11;
      4'b0011: md4_rot = 5'd19;
      4'b0100: md4_rot = 5'd3;
      4'b0101: md4_rot = 5'd5;
      4'b0110: md4_rot = 5'd9;
      4'b0111: md4_rot = 5'd13;
      4'b1000: md4_rot = 5'd3;
      4'b1001: md4_rot = 5'd9;
      4'b1010: md4_rot = 5'd11;
      4'b1011: md4_rot = 5'd15;
      default: md4_rot = 5'd3;
    endcase
  endfunction

  function automatic word_t md4_rotl(input word_t x, input logic [4:0] r);
    logic [63:0] t;
    t = {x, x} << r;
    md4_rotl = t[63:32];
  endfunction

endpackage

@@ hdl/md4_message_digest_unit.sv @@
// MD4 digest unit: byte absorption into a block memory, padding and compression.
`timescale 1ns / 1ps
// Each data item is written into the block memory; every 64th byte starts a compression
// (a read lead step, 48 steps on the single read port of the block memory, a fold).
// Finish: up to 71 padding bytes plus one or two compressions, then the digest
// sits in the output register. No input is taken during padding or compression.
// Reset: synchronous, active high; chaining words return to the initial value, the bit
// count to zero; block memory contents are not cleared.

module md4_message_digest_unit
  import md4_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_word0, digest_word1, digest_word2, digest_word3
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_CEND = 3'd3;

  logic [2:0]  state;
  logic [63:0] cnt;
  logic [63:0] len;
  logic        fin;
  logic        lenph;
  logic [5:0]  step;
  word_t       a, b, c, d;
  word_t       cv [4];
  word_t       mem [16];
  word_t       rdata;

  logic [5:0]  pos;
  logic        accept;
  logic        mem_we;
  logic [7:0]  mem_wbyte;
  logic [3:0]  raddr;
  logic        lenph_next;
  logic [5:0]  j;
  word_t       f, kc, sum, t;
  word_t       s0, s1, s2, s3;
  logic        emit_ok;
  logic        emit;

  assign pos = cnt[8:3];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign lenph_next = lenph || (pos == POS_LEN);
  assign emit_ok = !m_axis_tvalid || m_axis_tready;
  assign emit = (state == ST_CEND) && fin && lenph && emit_ok;
  assign raddr = md4_word_sel(step);
  assign j = step - 6'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_wbyte = 8'h00;
    if (state == ST_IDLE) begin
      mem_we = accept;
      mem_wbyte = s_axis_tuser ? PAD_BYTE : s_axis_tdata;
    end else if (state == ST_PAD) begin
      mem_we = 1'b1;
      mem_wbyte = lenph_next ? len[{pos[2:0], 3'b000} +: 8] : 8'h00;
    end
  end

  always_comb begin
    case (j[5:4])
      ROUND_F: begin
        f = (b & c) | (~b & d);
        kc = '0;
      end
      ROUND_G: begin
        f = (b & c) | (b & d) | (c & d);
        kc = K2;
      end
      default: begin
        f = b ^ c ^ d;
        kc = K3;
      end
    endcase
    sum = a + f + rdata + kc;
    t = md4_rotl(sum, md4_rot(j));
    s0 = cv[0] + a;
    s1 = cv[1] + b;
    s2 = cv[2] + c;
    s3 = cv[3] + d;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= mem_wbyte;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      fin <= 1'b0;
      lenph <= 1'b0;
      step <= '0;
      cv[0] <= IV0;
      cv[1] <= IV1;
      cv[2] <= IV2;
      cv[3] <= IV3;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= cnt + 64'd8;
            if (s_axis_tuser) begin
              len <= cnt;
              fin <= 1'b1;
              lenph <= 1'b0;
            end
            if (pos == POS_LAST) begin
              state <= ST_COMP;
            end else if (s_axis_tuser) begin
              state <= ST_PAD;
            end
          end
          step <= '0;
          a <= cv[0];
          b <= cv[1];
          c <= cv[2];
          d <= cv[3];
        end
        ST_PAD: begin
          cnt <= cnt + 64'd8;
          lenph <= lenph_next;
          step <= '0;
          a <= cv[0];
          b <= cv[1];
          c <= cv[2];
          d <= cv[3];
          if (pos == POS_LAST) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          if (step != 6'd0) begin
            a <= d;
            d <= c;
            c <= b;
            b <= t;
          end
          step <= step + 6'd1;
          if (step == STEP_LAST) begin
            state <= ST_CEND;
          end
        end
        ST_CEND: begin
          if (fin && lenph) begin
            if (emit_ok) begin
              m_axis_tdata <= {s3, s2, s1, s0};
              m_axis_tvalid <= 1'b1;
              cv[0] <= IV0;
              cv[1] <= IV1;
              cv[2] <= IV2;
              cv[3] <= IV3;
              cnt <= '0;
              fin <= 1'b0;
              lenph <= 1'b0;
              state <= ST_IDLE;
            end
          end else begin
            cv[0] <= s0;
            cv[1] <= s1;
            cv[2] <= s2;
            cv[3] <= s3;
            state <= fin ? ST_PAD : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_emit_from_fold: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_CEND) && $past(fin) && (cnt == 64'd0))
    else $error("digest emitted outside the final fold");

  a_full_block_compresses: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (pos == POS_LAST)) |=> (state == ST_COMP) && (step == 6'd0))
    else $error("full block did not start compression");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMP) |-> (step <= STEP_LAST))
    else $error("compression step out of range");

  a_no_write_in_comp: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMP) || (state == ST_CEND)) |-> !mem_we && !s_axis_tready)
    else $error("block memory written during compression");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking stream testbench for the MD4 message digest unit.
`timescale 1ns / 1ps

module testbench;
  import md4_pkg::*;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
  } md4_input_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // data_byte
  logic         s_axis_tuser = 1'b0;    // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;           // digest_word0, digest_word1, digest_word2, digest_word3

  md4_message_digest_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  int md4_word_order [0:47] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
    0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
  };
  int md4_shift [0:11] = '{3, 7, 11, 19, 3, 5, 9, 13, 3, 9, 11, 15};

  logic [31:0]  hash_h [0:3];
  logic [7:0]   msg_blk [0:63];
  logic [63:0]  msg_bits;

  md4_input_t   feed_q [$];
  logic [127:0] digest_q [$];

  int  in_gap = 0;
  int  out_gap = 0;
  int  items_sent = 0;
  int  digests_seen = 0;
  int  messages = 0;
  int  errors = 0;
  bit  calm = 1'b0;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void md4_compress();
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, f, k, t;
    int rnd;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_blk[4*i+3], msg_blk[4*i+2], msg_blk[4*i+1], msg_blk[4*i]};
    end
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    for (int i = 0; i < 48; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          k = 32'h0;
        end
        1: begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end
        default: begin
          f = b ^ c ^ d;
          k = K3;
        end
      endcase
      t = rol32(a + f + w[md4_word_order[i]] + k, md4_shift[rnd * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = t;
    end
    hash_h[0] = hash_h[0] + a;
    hash_h[1] = hash_h[1] + b;
    hash_h[2] = hash_h[2] + c;
    hash_h[3] = hash_h[3] + d;
  endfunction

  function automatic void md4_absorb(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    msg_blk[pos] = v;
    msg_bits = msg_bits + 64'd8;
    if (pos == POS_LAST) md4_compress();
  endfunction

  function automatic void md4_restart();
    hash_h[0] = IV0;
    hash_h[1] = IV1;
    hash_h[2] = IV2;
    hash_h[3] = IV3;
    msg_bits = 64'd0;
  endfunction

  function automatic logic [127:0] md4_finish();
    logic [63:0]  len;
    logic [127:0] dig;
    len = msg_bits;
    md4_absorb(PAD_BYTE);
    while (msg_bits[8:3] != POS_LEN) md4_absorb(8'h00);
    for (int i = 0; i < 8; i++) md4_absorb(len[8*i +: 8]);
    dig = {hash_h[3], hash_h[2], hash_h[1], hash_h[0]};
    md4_restart();
    return dig;
  endfunction

  function automatic void md4_take(input md4_input_t it);
    if (it.kind == KIND_DATA) begin
      md4_absorb(it.value);
    end else begin
      digest_q.push_back(md4_finish());
    end
  endfunction

  function automatic void add_byte(input logic [7:0] v);
    md4_input_t it;
    it.kind = KIND_DATA;
    it.value = v;
    feed_q.push_back(it);
  endfunction

  function automatic void add_finish();
    md4_input_t it;
    it.kind = KIND_FINISH;
    it.value = 8'($urandom);
    feed_q.push_back(it);
    messages++;
  endfunction

  function automatic void add_message(input int len);
    int style;
    style = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if (style == 0) add_byte($urandom_range(0, 1) ? 8'hFF : 8'h00);
      else add_byte(8'($urandom));
    end
    add_finish();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        md4_take(feed_q.pop_front());
        items_sent++;
      end
      calm = feed_q.size() < 100;
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (feed_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 14) - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= feed_q[0].value;
          s_axis_tuser <= feed_q[0].kind;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          $display("%0t: digest with none expected, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          logic [127:0] want;
          want = digest_q.pop_front();
          for (int w = 0; w < 4; w++) begin
            if (want[32*w +: 32] !== m_axis_tdata[32*w +: 32]) begin
              $display("%0t: digest_word%0d expected %h, actual %h", $time, w,
                       want[32*w +: 32], m_axis_tdata[32*w +: 32]);
              errors++;
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 14) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int edge_lens [0:7];
    int r;
    edge_lens = '{55, 56, 57, 63, 64, 65, 119, 120};
    md4_restart();
    for (int i = 0; i < 64; i++) msg_blk[i] = 8'h00;

    add_finish();
    add_byte(8'h00);
    add_finish();
    add_byte(8'hFF);
    add_finish();
    add_byte(8'h61);
    add_byte(8'h62);
    add_byte(8'h63);
    add_finish();
    add_byte(8'h80);
    add_finish();

    while (feed_q.size() < 600 || messages < 40) begin
      r = $urandom_range(0, 9);
      if (r < 5) add_message($urandom_range(0, 12));
      else if (r < 8) add_message(edge_lens[$urandom_range(0, 7)]);
      else add_message($urandom_range(0, 200));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (digest_q.size() > 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("covered %0d items in %0d messages, %0d digests compared", items_sent,
             messages, digests_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d digests outstanding", digest_q.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/md4_pkg.sv
hdl/md4_message_digest_unit.sv
tb/sv/testbench.sv
